// ===== rtl/hierarchical_timer_wheel_defines.svh =====
// assertion macros for the hierarchical timer wheel
// used by the top level only, needs aclk and aresetn in scope
`ifndef HIERARCHICAL_TIMER_WHEEL_DEFINES_SVH
`define HIERARCHICAL_TIMER_WHEEL_DEFINES_SVH

// condition holds at every edge out of reset
`define HTW_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define HTW_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hwt_pkg.sv =====
// constants, codes and placement helpers of the hierarchical timer wheel
// no dependencies
package hwt_pkg;

    localparam int MAX_TIMERS = 32;
    localparam int IDX_W      = $clog2(MAX_TIMERS);
    localparam int SLOT_BITS  = 8;
    localparam int LEVELS     = 4;
    localparam int LVL_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CNT_W      = 6;

    localparam logic [1:0] K_ADD    = 2'd0;
    localparam logic [1:0] K_UPDATE = 2'd1;
    localparam logic [1:0] K_REMOVE = 2'd2;
    localparam logic [1:0] K_TICK   = 2'd3;

    localparam logic [2:0] RK_ADDED   = 3'd0;
    localparam logic [2:0] RK_UPDATED = 3'd1;
    localparam logic [2:0] RK_REMOVED = 3'd2;
    localparam logic [2:0] RK_FIRED   = 3'd3;
    localparam logic [2:0] RK_SUMMARY = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [LVL_W-1:0]     level;
        logic [SLOT_BITS-1:0] slot;
    } place_t;

    // forward distance, zero when not ahead
    function automatic logic [31:0] ahead(input logic [31:0] t, input logic [31:0] now);
        logic [31:0] d;
        d = t - now;
        return d[31] ? 32'd0 : d;
    endfunction

    function automatic place_t place(input logic [31:0] expiry, input logic [31:0] now);
        logic [31:0] d;
        logic [31:0] nxt;
        place_t      p;
        d = ahead(expiry, now);
        p.level = '0;
        for (int i = 0; i < LEVELS - 1; i++) begin
            if ({32'd0, d} >= (64'd1 << (SLOT_BITS * (i + 1)))) begin
                p.level = LVL_W'(i + 1);
            end
        end
        nxt = now + 32'd1;
        if (d == 32'd0) begin
            p.slot = nxt[SLOT_BITS-1:0];
        end else begin
            p.slot = SLOT_BITS'(expiry >> (SLOT_BITS * p.level));
        end
        return p;
    endfunction

endpackage

// ===== rtl/hierarchical_timer_wheel.sv =====
// Hierarchical timer wheel over a table of MAX_TIMERS entries, four levels of 256 slots.
// One sequencer walks the table one entry per cycle, unless an output stall holds it,
// through a shared placement and distance unit. Add, update and remove search the table
// for the id or a free entry. A tick scans the table once per due level (level 0
// always, higher levels when time crosses their interval), scans it again for the
// earliest expiry when needed, then walks it to send fired words, stretched by any
// output stall. The input is not ready while an item is in work. Depends on hwt_pkg.
`include "hierarchical_timer_wheel_defines.svh"

module hierarchical_timer_wheel
    import hwt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // timer_id[31:0], duration[62:32], zero
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // status[1:0], id[33:2], next_timeout[65:34], count[71:66]
    output logic [2:0]  m_tuser,   // result_kind[2:0]
    output logic        m_tlast
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FIND  = 4'd1;
    localparam logic [3:0] S_WRITE = 4'd2;
    localparam logic [3:0] S_PLACE = 4'd3;
    localparam logic [3:0] S_TINC  = 4'd4;
    localparam logic [3:0] S_TLVL  = 4'd5;
    localparam logic [3:0] S_TSCAN = 4'd6;
    localparam logic [3:0] S_TMIN  = 4'd7;
    localparam logic [3:0] S_TFIRE = 4'd8;
    localparam logic [3:0] S_TSUM  = 4'd9;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_TIMERS - 1);

    logic [3:0]            state_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [LVL_W-1:0]      lvl_reg;
    logic [1:0]            kind_reg;
    logic [31:0]           tid_reg;
    logic [30:0]           dur_reg;
    logic [31:0]           time_reg;
    logic [31:0]           idc_reg;
    logic [31:0]           earliest_reg;
    logic                  dirty_reg;
    logic                  have_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [MAX_TIMERS-1:0] valid_reg;
    logic [MAX_TIMERS-1:0] fired_reg;
    logic [31:0]           ident_reg  [MAX_TIMERS];
    logic [31:0]           expiry_reg [MAX_TIMERS];
    logic [LVL_W-1:0]      level_reg  [MAX_TIMERS];
    logic [SLOT_BITS-1:0]  slot_reg   [MAX_TIMERS];

    logic                  m_valid_reg;
    logic [2:0]            o_kind_reg;
    logic [1:0]            o_status_reg;
    logic [31:0]           o_id_reg;
    logic [31:0]           o_nt_reg;
    logic [CNT_W-1:0]      o_cnt_reg;
    logic                  o_last_reg;

    logic                  out_free;
    logic                  idx_end;
    logic [31:0]           cur_exp;
    logic [31:0]           cur_ahead;
    logic [31:0]           earl_ahead;
    place_t                cur_place;
    logic [SLOT_BITS-1:0]  slot_due;
    logic                  lvl_due;
    logic                  hit;
    logic [63:0]           lvl_mask;

    assign out_free   = !m_valid_reg || m_tready;
    assign idx_end    = (idx_reg == IDX_LAST);
    assign cur_exp    = expiry_reg[idx_reg];
    assign cur_ahead  = ahead(cur_exp, time_reg);
    assign earl_ahead = ahead(earliest_reg, time_reg);
    assign cur_place  = place(cur_exp, time_reg);
    assign slot_due   = SLOT_BITS'(time_reg >> (SLOT_BITS * lvl_reg));
    assign lvl_mask   = (64'd1 << (SLOT_BITS * lvl_reg)) - 64'd1;
    assign lvl_due    = (({32'd0, time_reg} & lvl_mask) == 64'd0);
    assign hit        = valid_reg[idx_reg] && (level_reg[idx_reg] == lvl_reg) &&
                        (slot_reg[idx_reg] == slot_due);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_kind_reg;
    assign m_tdata  = {o_cnt_reg, o_nt_reg, o_id_reg, o_status_reg};
    assign m_tlast  = o_last_reg;

    // table payload, no reset
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_WRITE: begin
                if (kind_reg == K_ADD) begin
                    ident_reg[idx_reg]  <= idc_reg + 32'd1;
                    expiry_reg[idx_reg] <= time_reg + {1'b0, dur_reg};
                end else if (kind_reg == K_UPDATE) begin
                    expiry_reg[idx_reg] <= time_reg + {1'b0, dur_reg};
                end
            end
            S_PLACE: begin
                if (out_free) begin
                    level_reg[idx_reg] <= cur_place.level;
                    slot_reg[idx_reg]  <= cur_place.slot;
                end
            end
            S_TSCAN: begin
                if (hit && cur_ahead != 32'd0) begin
                    level_reg[idx_reg] <= cur_place.level;
                    slot_reg[idx_reg]  <= cur_place.slot;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            lvl_reg      <= '0;
            time_reg     <= '0;
            idc_reg      <= '0;
            earliest_reg <= '0;
            dirty_reg    <= 1'b0;
            have_reg     <= 1'b0;
            count_reg    <= '0;
            valid_reg    <= '0;
            fired_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        kind_reg <= s_tuser;
                        tid_reg  <= s_tdata[31:0];
                        dur_reg  <= s_tdata[62:32];
                        idx_reg  <= '0;
                        state_reg <= (s_tuser == K_TICK) ? S_TINC : S_FIND;
                    end
                end
                S_FIND: begin
                    if ((kind_reg == K_ADD && !valid_reg[idx_reg]) ||
                        (kind_reg != K_ADD && valid_reg[idx_reg] &&
                         ident_reg[idx_reg] == tid_reg)) begin
                        state_reg <= S_WRITE;
                    end else if (!idx_end) begin
                        idx_reg <= idx_reg + 1'b1;
                    end else if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        o_kind_reg   <= {1'b0, kind_reg};
                        o_status_reg <= (kind_reg == K_ADD) ? ST_FULL : ST_NOT_FOUND;
                        o_id_reg     <= (kind_reg == K_ADD) ? 32'd0 : tid_reg;
                        o_nt_reg     <= '0;
                        o_cnt_reg    <= count_reg;
                        o_last_reg   <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                S_WRITE: begin
                    if (kind_reg == K_ADD) begin
                        idc_reg            <= idc_reg + 32'd1;
                        valid_reg[idx_reg] <= 1'b1;
                        state_reg          <= S_PLACE;
                    end else if (kind_reg == K_UPDATE) begin
                        if (cur_exp == earliest_reg) begin
                            dirty_reg <= 1'b1;
                        end
                        state_reg <= S_PLACE;
                    end else if (out_free) begin
                        valid_reg[idx_reg] <= 1'b0;
                        if (cur_exp == earliest_reg) begin
                            dirty_reg <= 1'b1;
                        end
                        m_valid_reg  <= 1'b1;
                        o_kind_reg   <= RK_REMOVED;
                        o_status_reg <= ST_OK;
                        o_id_reg     <= tid_reg;
                        o_nt_reg     <= '0;
                        o_cnt_reg    <= (count_reg != '0) ? count_reg - 1'b1 : count_reg;
                        o_last_reg   <= 1'b1;
                        if (count_reg != '0) begin
                            count_reg <= count_reg - 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_PLACE: begin
                    if (out_free) begin
                        if (count_reg == '0 || cur_ahead < earl_ahead) begin
                            earliest_reg <= cur_exp;
                        end
                        m_valid_reg  <= 1'b1;
                        o_status_reg <= ST_OK;
                        o_nt_reg     <= '0;
                        o_last_reg   <= 1'b1;
                        if (kind_reg == K_ADD) begin
                            count_reg  <= count_reg + 1'b1;
                            o_kind_reg <= RK_ADDED;
                            o_id_reg   <= idc_reg;
                            o_cnt_reg  <= count_reg + 1'b1;
                        end else begin
                            o_kind_reg <= RK_UPDATED;
                            o_id_reg   <= tid_reg;
                            o_cnt_reg  <= count_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_TINC: begin
                    time_reg  <= time_reg + 32'd1;
                    lvl_reg   <= LVL_W'(LEVELS - 1);
                    fired_reg <= '0;
                    state_reg <= S_TLVL;
                end
                S_TLVL: begin
                    idx_reg <= '0;
                    if (lvl_due) begin
                        state_reg <= S_TSCAN;
                    end else begin
                        lvl_reg <= lvl_reg - 1'b1;
                    end
                end
                S_TSCAN: begin
                    if (hit && cur_ahead == 32'd0) begin
                        valid_reg[idx_reg] <= 1'b0;
                        fired_reg[idx_reg] <= 1'b1;
                        if (cur_exp == earliest_reg) begin
                            dirty_reg <= 1'b1;
                        end
                        if (count_reg != '0) begin
                            count_reg <= count_reg - 1'b1;
                        end
                    end
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_end) begin
                        idx_reg <= '0;
                        have_reg <= 1'b0;
                        if (lvl_reg == '0) begin
                            state_reg <= S_TMIN;
                        end else begin
                            lvl_reg   <= lvl_reg - 1'b1;
                            state_reg <= S_TLVL;
                        end
                    end
                end
                S_TMIN: begin
                    if (count_reg == '0) begin
                        earliest_reg <= '0;
                        dirty_reg    <= 1'b0;
                        state_reg    <= S_TFIRE;
                    end else if (!dirty_reg) begin
                        state_reg <= S_TFIRE;
                    end else begin
                        if (valid_reg[idx_reg] && (!have_reg || cur_ahead < earl_ahead)) begin
                            earliest_reg <= cur_exp;
                            have_reg     <= 1'b1;
                        end
                        idx_reg <= idx_reg + 1'b1;
                        if (idx_end) begin
                            idx_reg   <= '0;
                            dirty_reg <= 1'b0;
                            state_reg <= S_TFIRE;
                        end
                    end
                end
                S_TFIRE: begin
                    if (!fired_reg[idx_reg] || out_free) begin
                        if (fired_reg[idx_reg]) begin
                            m_valid_reg  <= 1'b1;
                            o_kind_reg   <= RK_FIRED;
                            o_status_reg <= ST_OK;
                            o_id_reg     <= ident_reg[idx_reg];
                            o_nt_reg     <= '0;
                            o_cnt_reg    <= count_reg;
                            o_last_reg   <= 1'b0;
                        end
                        idx_reg <= idx_reg + 1'b1;
                        if (idx_end) begin
                            state_reg <= S_TSUM;
                        end
                    end
                end
                S_TSUM: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        o_kind_reg   <= RK_SUMMARY;
                        o_status_reg <= ST_OK;
                        o_id_reg     <= '0;
                        o_nt_reg     <= (count_reg == '0) ? 32'hFFFF_FFFF : earl_ahead;
                        o_cnt_reg    <= count_reg;
                        o_last_reg   <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // pending count tracks the valid entries between items
    `HTW_ASSERT_IMPLIES(a_count_matches, state_reg == S_IDLE, $countones(valid_reg) == 32'(count_reg), "count mismatch")
    // summary word always closes the item
    `HTW_ASSERT_IMPLIES(a_summary_last, m_valid_reg && o_kind_reg == RK_SUMMARY, o_last_reg, "summary not last")
    // fired words never close the item
    `HTW_ASSERT_IMPLIES(a_fired_not_last, m_valid_reg && o_kind_reg == RK_FIRED, !o_last_reg, "fired word marked last")

endmodule
